### hw/rtl/dccc_pkg.sv
// Shared types, constants and calendar helpers for the day-count calendar converter.
// Used by dccc_front, dccc_queue, dccc_back and the top level; no dependencies.
`default_nettype none

package dccc_pkg;

  localparam logic [11:0] BASE_YEAR  = 12'd2008;
  localparam logic [11:0] MAX_SPAN   = 12'd180;
  localparam logic [15:0] MAX_COUNT  = 16'hFFFF;
  localparam logic [16:0] MAX_TOTAL  = 17'd65535;
  localparam logic [15:0] FOUR_YEARS = 16'd1461;
  localparam logic [15:0] LEAP_LEN   = 16'd366;
  localparam logic [15:0] YEAR_LEN   = 16'd365;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_DATE = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_CLAMP = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_DATE,
    OP_NUM,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        clamped;
    logic [15:0] count;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DBASE,
    S_DMON,
    S_DCHK,
    S_QUAD,
    S_YEAR,
    S_MON,
    S_DONE
  } seq_state_t;

  // Valid for years from the base year through 2099; the base year is a leap year.
  function automatic logic is_leap(logic [11:0] year);
    return year[1:0] == 2'b00;
  endfunction

  function automatic logic [4:0] month_len(logic [11:0] year, logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = is_leap(year) ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/day_count_calendar_converter_core.sv
// Day-count calendar converter, top level: front end, request queue and sequencer.
// Depends on dccc_pkg, dccc_front, dccc_queue and dccc_back.
`default_nettype none

// Keeps a day count (2008-01-01 is day 1) and the matching date, and returns one
// result per request with the state after it. A tick or unknown kind passes straight
// to the result state; a date load walks each preceding month, and a number load
// walks four-year blocks (up to 44 blocks), then single years (up to 3) and months
// (up to 11), one step per cycle. A date load that saturates adds the same walk.
// The queue of QUEUE_DEPTH requests lets new requests in while the sequencer is
// busy or a result waits to be taken.
module day_count_calendar_converter_core
  import dccc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [11:0] load_year,
  input  wire logic [3:0]  load_month,
  input  wire logic [4:0]  load_day,
  input  wire logic [15:0] load_day_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [15:0]      out_day_number,
  output logic [1:0]       status
);

  req_t push_entry;
  req_t head_entry;
  logic push;
  logic q_ready;
  logic q_valid;
  logic q_pop;

  dccc_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .load_year       (load_year),
    .load_month      (load_month),
    .load_day        (load_day),
    .load_day_number (load_day_number),
    .q_ready         (q_ready),
    .q_push          (push),
    .q_entry         (push_entry)
  );

  dccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .entry      (head_entry)
  );

  dccc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_entry        (head_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_day_number (out_day_number),
    .status         (status)
  );

endmodule

`default_nettype wire

### hw/rtl/dccc_front.sv
// Front end: accepts requests, decodes the kind and sanitizes date fields.
// Depends on dccc_pkg; feeds dccc_queue.
`default_nettype none

module dccc_front
  import dccc_pkg::*;
(
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [11:0] load_year,
  input  wire logic [3:0]  load_month,
  input  wire logic [4:0]  load_day,
  input  wire logic [15:0] load_day_number,
  input  wire logic        q_ready,
  output logic             q_push,
  output req_t             q_entry
);

  logic [11:0] year_c;
  logic [3:0]  month_c;
  logic [4:0]  day_c;
  logic [4:0]  len_c;
  logic        clamped;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Clamp the date fields; the day limit follows the clamped year and month.
  always_comb begin
    clamped = 1'b0;
    year_c  = load_year;
    month_c = load_month;
    day_c   = load_day;
    if (load_year < BASE_YEAR) begin
      year_c  = BASE_YEAR;
      clamped = 1'b1;
    end
    if (load_month < MONTH_JAN) begin
      month_c = MONTH_JAN;
      clamped = 1'b1;
    end else if (load_month > MONTH_DEC) begin
      month_c = MONTH_DEC;
      clamped = 1'b1;
    end
    len_c = month_len(year_c, month_c);
    if (load_day == 5'd0) begin
      day_c   = 5'd1;
      clamped = 1'b1;
    end else if (load_day > len_c) begin
      day_c   = len_c;
      clamped = 1'b1;
    end
  end

  always_comb begin
    q_entry.year    = year_c;
    q_entry.month   = month_c;
    q_entry.day     = day_c;
    q_entry.clamped = clamped;
    q_entry.count   = (load_day_number == 16'd0) ? 16'd1 : load_day_number;
    case (kind)
      KIND_TICK: q_entry.op = OP_TICK;
      KIND_DATE: q_entry.op = OP_DATE;
      KIND_NUM:  q_entry.op = OP_NUM;
      default:   q_entry.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dccc_queue.sv
// Short request queue between the front end and the sequencer.
// Depends on dccc_pkg for the request type.
`default_nettype none

module dccc_queue
  import dccc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_entry,
  output logic      ready,
  input  wire logic pop,
  output logic      valid,
  output req_t      entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign ready = count != CNT_W'(DEPTH);
  assign valid = count != '0;
  assign entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dccc_back.sv
// Back end: holds the calendar state and runs each request as a short sequence.
// Depends on dccc_pkg; pops requests from dccc_queue, drives the result register.
`default_nettype none

module dccc_back
  import dccc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire req_t        q_entry,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [15:0]      out_day_number,
  output logic [1:0]       status
);

  seq_state_t  state, state_next;

  logic [15:0] day_count, day_count_next;
  logic [11:0] cur_year, cur_year_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [4:0]  cur_day, cur_day_next;

  logic [11:0] ld_year, ld_year_next;
  logic [3:0]  ld_month, ld_month_next;
  logic [4:0]  ld_day, ld_day_next;
  logic        ld_clamped, ld_clamped_next;
  logic [16:0] acc, acc_next;
  logic [3:0]  idx, idx_next;
  logic [15:0] rem, rem_next;
  logic [1:0]  stat, stat_next;

  logic        out_valid_next;
  logic [11:0] out_year_next;
  logic [3:0]  out_month_next;
  logic [4:0]  out_day_next;
  logic [15:0] out_day_number_next;
  logic [1:0]  status_next;

  logic [11:0] span;
  logic        span_over;
  logic [4:0]  cur_len;
  logic [15:0] year_len;
  logic        quad_more;
  logic        year_more;
  logic        mon_more;
  logic        slot_free;

  assign span      = ld_year - BASE_YEAR;
  assign span_over = span >= MAX_SPAN;
  assign cur_len   = month_len(cur_year, cur_month);
  assign year_len  = is_leap(cur_year) ? LEAP_LEN : YEAR_LEN;
  assign quad_more = rem >= FOUR_YEARS;
  assign year_more = rem >= year_len;
  assign mon_more  = (cur_month < MONTH_DEC) && (rem >= 16'(cur_len));
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_entry.op)
            OP_DATE: state_next = S_DBASE;
            OP_NUM:  state_next = S_QUAD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_DBASE: state_next = span_over ? S_QUAD : S_DMON;
      S_DMON:  state_next = (idx < ld_month) ? S_DMON : S_DCHK;
      S_DCHK:  state_next = (acc > MAX_TOTAL) ? S_QUAD : S_DONE;
      S_QUAD:  state_next = quad_more ? S_QUAD : S_YEAR;
      S_YEAR:  state_next = year_more ? S_YEAR : S_MON;
      S_MON:   state_next = mon_more ? S_MON : S_DONE;
      S_DONE:  state_next = slot_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop               = 1'b0;
    day_count_next      = day_count;
    cur_year_next       = cur_year;
    cur_month_next      = cur_month;
    cur_day_next        = cur_day;
    ld_year_next        = ld_year;
    ld_month_next       = ld_month;
    ld_day_next         = ld_day;
    ld_clamped_next     = ld_clamped;
    acc_next            = acc;
    idx_next            = idx;
    rem_next            = rem;
    stat_next           = stat;
    out_valid_next      = out_valid && !out_ready;
    out_year_next       = out_year;
    out_month_next      = out_month;
    out_day_next        = out_day;
    out_day_number_next = out_day_number;
    status_next         = status;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop           = 1'b1;
          ld_year_next    = q_entry.year;
          ld_month_next   = q_entry.month;
          ld_day_next     = q_entry.day;
          ld_clamped_next = q_entry.clamped;
          stat_next       = STAT_OK;
          case (q_entry.op)
            OP_TICK: begin
              if (day_count == MAX_COUNT) begin
                stat_next = STAT_SAT;
              end else begin
                day_count_next = day_count + 16'd1;
                if (cur_day < cur_len) begin
                  cur_day_next = cur_day + 5'd1;
                end else begin
                  cur_day_next = 5'd1;
                  if (cur_month < MONTH_DEC) begin
                    cur_month_next = cur_month + 4'd1;
                  end else begin
                    cur_month_next = MONTH_JAN;
                    cur_year_next  = cur_year + 12'd1;
                  end
                end
              end
            end
            OP_NUM: begin
              day_count_next = q_entry.count;
              rem_next       = q_entry.count - 16'd1;
              cur_year_next  = BASE_YEAR;
              cur_month_next = MONTH_JAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_DBASE: begin
        if (span_over) begin
          // Saturate and rebuild the date from the top count
          day_count_next = MAX_COUNT;
          rem_next       = MAX_COUNT - 16'd1;
          cur_year_next  = BASE_YEAR;
          cur_month_next = MONTH_JAN;
          stat_next      = STAT_SAT;
        end else begin
          acc_next = ({9'd0, span[7:0]} * 17'd365) + 17'((span + 12'd3) >> 2);
          idx_next = MONTH_JAN;
        end
      end
      S_DMON: begin
        if (idx < ld_month) begin
          acc_next = acc + 17'(month_len(ld_year, idx));
          idx_next = idx + 4'd1;
        end else begin
          acc_next = acc + 17'(ld_day);
        end
      end
      S_DCHK: begin
        if (acc > MAX_TOTAL) begin
          day_count_next = MAX_COUNT;
          rem_next       = MAX_COUNT - 16'd1;
          cur_year_next  = BASE_YEAR;
          cur_month_next = MONTH_JAN;
          stat_next      = STAT_SAT;
        end else begin
          day_count_next = acc[15:0];
          cur_year_next  = ld_year;
          cur_month_next = ld_month;
          cur_day_next   = ld_day;
          stat_next      = ld_clamped ? STAT_CLAMP : STAT_OK;
        end
      end
      S_QUAD: begin
        if (quad_more) begin
          rem_next      = rem - FOUR_YEARS;
          cur_year_next = cur_year + 12'd4;
        end
      end
      S_YEAR: begin
        if (year_more) begin
          rem_next      = rem - year_len;
          cur_year_next = cur_year + 12'd1;
        end
      end
      S_MON: begin
        if (mon_more) begin
          rem_next       = rem - 16'(cur_len);
          cur_month_next = cur_month + 4'd1;
        end else begin
          cur_day_next = rem[4:0] + 5'd1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_year_next       = cur_year;
          out_month_next      = cur_month;
          out_day_next        = cur_day;
          out_day_number_next = day_count;
          status_next         = stat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      day_count <= 16'd1;
      cur_year  <= BASE_YEAR;
      cur_month <= MONTH_JAN;
      cur_day   <= 5'd1;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      day_count <= day_count_next;
      cur_year  <= cur_year_next;
      cur_month <= cur_month_next;
      cur_day   <= cur_day_next;
    end
  end

  always_ff @(posedge clk) begin
    ld_year        <= ld_year_next;
    ld_month       <= ld_month_next;
    ld_day         <= ld_day_next;
    ld_clamped     <= ld_clamped_next;
    acc            <= acc_next;
    idx            <= idx_next;
    rem            <= rem_next;
    stat           <= stat_next;
    out_year       <= out_year_next;
    out_month      <= out_month_next;
    out_day        <= out_day_next;
    out_day_number <= out_day_number_next;
    status         <= status_next;
  end

`ifndef SYNTH
  a_idle_date_ok: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> day_count != 16'd0 && cur_month >= MONTH_JAN &&
      cur_month <= MONTH_DEC && cur_day != 5'd0 &&
      cur_day <= month_len(cur_year, cur_month))
    else $error("calendar state inconsistent while idle");

  a_sat_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_SAT |-> out_day_number == MAX_COUNT)
    else $error("saturated result without top day count");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE)
    else $error("request popped but sequencer stayed idle");

  a_year_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_YEAR |-> rem < FOUR_YEARS && cur_month == MONTH_JAN)
    else $error("year walk entered with remainder out of range");
`endif

endmodule

`default_nettype wire
